### rtl/dpb_pkg.sv
// ============================================================================
// dpb_pkg: shared types for the depth pixel back-projection core
// Word formats of both channels, the queue entry, configuration and
// register index codes.
// ============================================================================
package dpb_pkg;

    localparam int IDX_W       = 16;   // pixel index field width in the queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef enum logic [2:0] {
        REG_DEPTH_SCALE = 3'd0,
        REG_MIN_DEPTH   = 3'd1,
        REG_MAX_DEPTH   = 3'd2,
        REG_CENTER_X    = 3'd3,
        REG_CENTER_Y    = 3'd4,
        REG_INV_FOCAL_X = 3'd5,
        REG_INV_FOCAL_Y = 3'd6,
        REG_SWAP_COLOR  = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [15:0] depth_raw;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [7:0]  third_byte;
        logic        start_of_frame;
        logic        end_of_line;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [31:0]        point_z;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } out_word_t;

    typedef struct packed {
        logic [15:0]      depth_raw;
        logic [7:0]       first_byte;
        logic [7:0]       second_byte;
        logic [7:0]       third_byte;
        logic [IDX_W-1:0] column;
        logic [IDX_W-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic [23:0] depth_scale;
        logic [31:0] min_depth;
        logic [31:0] max_depth;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [23:0] inv_focal_x;
        logic [23:0] inv_focal_y;
        logic        swap_color;
    } cfg_t;

endpackage

### rtl/depth_pixel_backprojection_core.sv
// Path of a kept pixel: input accept, queue entry, stages 1 to 4, output register.
// Throughput: one input word per cycle while the queue has room; kept pixels flow one per cycle
// through the multiplier pipeline, which holds as a whole while the output word waits.
// A 4-entry queue decouples pixel selection from the arithmetic pipeline.
// Reset (rst_n low, async): counters cleared, pipe empty, registers at defaults.
// ============================================================================
// depth_pixel_backprojection_core: depth pixel to camera-frame point
// Front end tracks raster position and selects subsampled pixels; back end
// scales depth, applies the depth window and back-projects through the
// pinhole model to Q16.16 x/y/z with the pixel color.
// ============================================================================
module depth_pixel_backprojection_core #(
    parameter int MAX_DIMENSION = 4096,
    parameter int STRIDE        = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    // pixel input
    input  logic               in_valid,
    output logic               in_ready,
    input  dpb_pkg::in_word_t  in_word,
    // point output
    output logic               out_valid,
    input  logic               out_ready,
    output dpb_pkg::out_word_t out_word,
    // configuration write port
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import dpb_pkg::*;

    cfg_t   cfg_reg;
    logic   queue_full, queue_empty, push, pop;
    pixel_t push_pixel, head_pixel;

    // Configuration registers. Index codes follow the register list; all
    // eight codes are in use, so no write is ever dropped for a bad index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_scale <= 24'd16777;
            cfg_reg.min_depth   <= 32'd655;
            cfg_reg.max_depth   <= 32'd655360;
            cfg_reg.center_x    <= 16'd5087;
            cfg_reg.center_y    <= 16'd3865;
            cfg_reg.inv_focal_x <= 24'd32559;
            cfg_reg.inv_focal_y <= 24'd32410;
            cfg_reg.swap_color  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_DEPTH_SCALE: cfg_reg.depth_scale <= cfg_data[23:0];
                REG_MIN_DEPTH:   cfg_reg.min_depth   <= cfg_data;
                REG_MAX_DEPTH:   cfg_reg.max_depth   <= cfg_data;
                REG_CENTER_X:    cfg_reg.center_x    <= cfg_data[15:0];
                REG_CENTER_Y:    cfg_reg.center_y    <= cfg_data[15:0];
                REG_INV_FOCAL_X: cfg_reg.inv_focal_x <= cfg_data[23:0];
                REG_INV_FOCAL_Y: cfg_reg.inv_focal_y <= cfg_data[23:0];
                REG_SWAP_COLOR:  cfg_reg.swap_color  <= cfg_data[0];
                default:         cfg_reg.swap_color  <= cfg_reg.swap_color;
            endcase
        end
    end

    // Front: position counters, start-of-frame / end-of-line handling, and
    // the stride test. Non-selected pixels are consumed without a queue slot.
    dpb_front #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .STRIDE        (STRIDE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .queue_full (queue_full),
        .push       (push),
        .pixel      (push_pixel)
    );

    // Queue: lets the front keep taking pixels while the output is stalled.
    dpb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_pixel),
        .pop     (pop),
        .rd_data (head_pixel),
        .full    (queue_full),
        .empty   (queue_empty)
    );

    // Back: depth scale, window drop, offset*z, *1/f as split partial
    // products, floor with sticky remainder, then saturation to int32.
    dpb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .queue_empty (queue_empty),
        .head        (head_pixel),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_word    (out_word)
    );

endmodule

### rtl/dpb_front.sv
// ============================================================================
// dpb_front: raster position tracking and pixel selection
// Keeps row/column counters and phases, passes every STRIDE-th pixel of
// every STRIDE-th row into the work queue.
// ============================================================================
module dpb_front #(
    parameter int MAX_DIMENSION = 4096,
    parameter int STRIDE        = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dpb_pkg::in_word_t in_word,
    input  logic              queue_full,
    output logic              push,
    output dpb_pkg::pixel_t   pixel
);
    import dpb_pkg::*;

    localparam int IW = $clog2(MAX_DIMENSION);
    localparam int PW = (STRIDE > 1) ? $clog2(STRIDE) : 1;
    localparam logic [IW:0] DIM_LIMIT   = (IW + 1)'(MAX_DIMENSION);
    localparam logic [PW:0] PHASE_LIMIT = (PW + 1)'(STRIDE);

    logic [IW-1:0] col_reg, col_next, row_reg, row_next;
    logic [PW-1:0] col_ph_reg, col_ph_next, row_ph_reg, row_ph_next;
    logic [IW-1:0] col_cur, row_cur, col_adv, row_adv;
    logic [PW-1:0] col_ph_cur, row_ph_cur, col_ph_adv, row_ph_adv;
    logic [IW:0]   col_inc, row_inc;
    logic [PW:0]   col_ph_inc, row_ph_inc;
    logic          accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        // start of frame clears position before the pixel is used
        col_cur    = in_word.start_of_frame ? '0 : col_reg;
        row_cur    = in_word.start_of_frame ? '0 : row_reg;
        col_ph_cur = in_word.start_of_frame ? '0 : col_ph_reg;
        row_ph_cur = in_word.start_of_frame ? '0 : row_ph_reg;

        col_inc    = {1'b0, col_cur} + (IW + 1)'(1);
        row_inc    = {1'b0, row_cur} + (IW + 1)'(1);
        col_ph_inc = {1'b0, col_ph_cur} + (PW + 1)'(1);
        row_ph_inc = {1'b0, row_ph_cur} + (PW + 1)'(1);
        col_adv    = (col_inc >= DIM_LIMIT) ? '0 : col_inc[IW-1:0];
        row_adv    = (row_inc >= DIM_LIMIT) ? '0 : row_inc[IW-1:0];
        col_ph_adv = (col_ph_inc >= PHASE_LIMIT) ? '0 : col_ph_inc[PW-1:0];
        row_ph_adv = (row_ph_inc >= PHASE_LIMIT) ? '0 : row_ph_inc[PW-1:0];

        col_next    = col_reg;
        row_next    = row_reg;
        col_ph_next = col_ph_reg;
        row_ph_next = row_ph_reg;
        if (accept)
        begin
            if (in_word.end_of_line)
            begin
                col_next    = '0;
                col_ph_next = '0;
                row_next    = row_adv;
                row_ph_next = row_ph_adv;
            end
            else
            begin
                col_next    = col_adv;
                col_ph_next = col_ph_adv;
                row_next    = row_cur;
                row_ph_next = row_ph_cur;
            end
        end
    end

    assign push = accept && (col_ph_cur == '0) && (row_ph_cur == '0);

    always_comb
    begin
        pixel.depth_raw   = in_word.depth_raw;
        pixel.first_byte  = in_word.first_byte;
        pixel.second_byte = in_word.second_byte;
        pixel.third_byte  = in_word.third_byte;
        pixel.column      = IDX_W'(col_cur);
        pixel.row         = IDX_W'(row_cur);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            col_ph_reg <= '0;
            row_ph_reg <= '0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            col_ph_reg <= col_ph_next;
            row_ph_reg <= row_ph_next;
        end
    end

`ifndef SYNTHESIS
    // frame start pixel sits at phase zero and must always be queued
    a_sof_selected: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_word.start_of_frame) |-> push)
        else $error("start of frame pixel not queued");
    a_eol_clears_col: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_word.end_of_line) |=> (col_reg == '0 && col_ph_reg == '0))
        else $error("column not cleared after end of line");
`endif

endmodule

### rtl/dpb_queue.sv
// ============================================================================
// dpb_queue: short FIFO between front and back
// Holds selected pixels so each side can stall independently.
// ============================================================================
module dpb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dpb_pkg::pixel_t wr_data,
    input  logic            pop,
    output dpb_pkg::pixel_t rd_data,
    output logic            full,
    output logic            empty
);
    import dpb_pkg::*;

    pixel_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full    = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");
`endif

endmodule

### rtl/dpb_back.sv
// ============================================================================
// dpb_back: depth scaling, window test and back-projection pipeline
// Five register stages including the output register; the whole pipe
// holds while the output word waits.
// ============================================================================
module dpb_back (
    input  logic               clk,
    input  logic               rst_n,
    input  dpb_pkg::cfg_t      cfg,
    input  logic               queue_empty,
    input  dpb_pkg::pixel_t    head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output dpb_pkg::out_word_t out_word
);
    import dpb_pkg::*;

    // floor division result to signed Q16.16 with saturation
    function automatic logic [31:0] finish_coord(input logic [47:0] q,
                                                 input logic rem,
                                                 input logic neg);
        logic [48:0] up;
        logic [31:0] res;
        up = {1'b0, q} + {48'd0, rem};
        if (neg)
        begin
            if (up >= 49'h0_8000_0000)
                res = 32'h8000_0000;
            else
                res = ~up[31:0] + 32'd1;
        end
        else
        begin
            if (q > 48'h7FFF_FFFF)
                res = 32'h7FFF_FFFF;
            else
                res = q[31:0];
        end
        return res;
    endfunction

    logic advance;

    // stage 1: depth in metres, offsets from principal point
    logic [39:0] raw_prod;
    logic [20:0] diff_x, diff_y, abs_x, abs_y;
    logic        s1_valid_reg, s1_valid_next;
    logic [31:0] s1_z_reg;
    logic [19:0] s1_mag_x_reg, s1_mag_y_reg;
    logic        s1_neg_x_reg, s1_neg_y_reg;
    logic [7:0]  s1_r_reg, s1_g_reg, s1_b_reg;

    // stage 2: window test, offset times depth
    logic        s2_valid_reg, s2_valid_next;
    logic [51:0] s2_px_reg, s2_py_reg, s2_px_next, s2_py_next;
    logic [31:0] s2_z_reg;
    logic        s2_neg_x_reg, s2_neg_y_reg;
    logic [7:0]  s2_r_reg, s2_g_reg, s2_b_reg;

    // stage 3: partial products with reciprocal focal length
    logic        s3_valid_reg;
    logic [49:0] s3_xlo_reg, s3_xhi_reg, s3_ylo_reg, s3_yhi_reg;
    logic [49:0] s3_xlo_next, s3_xhi_next, s3_ylo_next, s3_yhi_next;
    logic [31:0] s3_z_reg;
    logic        s3_neg_x_reg, s3_neg_y_reg;
    logic [7:0]  s3_r_reg, s3_g_reg, s3_b_reg;

    // stage 4: partial product sum, quotient and sticky remainder
    logic [75:0] x_full, y_full;
    logic        s4_valid_reg;
    logic [47:0] s4_qx_reg, s4_qy_reg;
    logic        s4_remx_reg, s4_remy_reg;
    logic [31:0] s4_z_reg;
    logic        s4_neg_x_reg, s4_neg_y_reg;
    logic [7:0]  s4_r_reg, s4_g_reg, s4_b_reg;

    logic        out_valid_reg;
    out_word_t   out_word_reg, out_word_next;

    assign advance       = !out_valid_reg || out_ready;
    assign pop           = advance && !queue_empty;
    assign out_valid     = out_valid_reg;
    assign out_word      = out_word_reg;
    assign s1_valid_next = !queue_empty;
    assign s2_valid_next = s1_valid_reg && (s1_z_reg >= cfg.min_depth)
                           && (s1_z_reg <= cfg.max_depth);

    always_comb
    begin
        raw_prod = 40'(head.depth_raw) * 40'(cfg.depth_scale);
        diff_x   = {1'b0, head.column, 4'b0000} - {5'd0, cfg.center_x};
        diff_y   = {1'b0, head.row, 4'b0000} - {5'd0, cfg.center_y};
        abs_x    = diff_x[20] ? (~diff_x + 21'd1) : diff_x;
        abs_y    = diff_y[20] ? (~diff_y + 21'd1) : diff_y;

        s2_px_next = 52'(s1_mag_x_reg) * 52'(s1_z_reg);
        s2_py_next = 52'(s1_mag_y_reg) * 52'(s1_z_reg);

        s3_xlo_next = 50'(s2_px_reg[25:0])  * 50'(cfg.inv_focal_x);
        s3_xhi_next = 50'(s2_px_reg[51:26]) * 50'(cfg.inv_focal_x);
        s3_ylo_next = 50'(s2_py_reg[25:0])  * 50'(cfg.inv_focal_y);
        s3_yhi_next = 50'(s2_py_reg[51:26]) * 50'(cfg.inv_focal_y);

        x_full = {26'd0, s3_xlo_reg} + {s3_xhi_reg, 26'd0};
        y_full = {26'd0, s3_ylo_reg} + {s3_yhi_reg, 26'd0};

        out_word_next.point_x = finish_coord(s4_qx_reg, s4_remx_reg, s4_neg_x_reg);
        out_word_next.point_y = finish_coord(s4_qy_reg, s4_remy_reg, s4_neg_y_reg);
        out_word_next.point_z = s4_z_reg;
        out_word_next.red     = s4_r_reg;
        out_word_next.green   = s4_g_reg;
        out_word_next.blue    = s4_b_reg;
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_z_reg     <= raw_prod[39:8];
            s1_mag_x_reg <= abs_x[19:0];
            s1_mag_y_reg <= abs_y[19:0];
            s1_neg_x_reg <= diff_x[20];
            s1_neg_y_reg <= diff_y[20];
            s1_r_reg     <= cfg.swap_color ? head.third_byte : head.first_byte;
            s1_g_reg     <= head.second_byte;
            s1_b_reg     <= cfg.swap_color ? head.first_byte : head.third_byte;

            s2_px_reg    <= s2_px_next;
            s2_py_reg    <= s2_py_next;
            s2_z_reg     <= s1_z_reg;
            s2_neg_x_reg <= s1_neg_x_reg;
            s2_neg_y_reg <= s1_neg_y_reg;
            s2_r_reg     <= s1_r_reg;
            s2_g_reg     <= s1_g_reg;
            s2_b_reg     <= s1_b_reg;

            s3_xlo_reg   <= s3_xlo_next;
            s3_xhi_reg   <= s3_xhi_next;
            s3_ylo_reg   <= s3_ylo_next;
            s3_yhi_reg   <= s3_yhi_next;
            s3_z_reg     <= s2_z_reg;
            s3_neg_x_reg <= s2_neg_x_reg;
            s3_neg_y_reg <= s2_neg_y_reg;
            s3_r_reg     <= s2_r_reg;
            s3_g_reg     <= s2_g_reg;
            s3_b_reg     <= s2_b_reg;

            s4_qx_reg    <= x_full[75:28];
            s4_qy_reg    <= y_full[75:28];
            s4_remx_reg  <= |x_full[27:0];
            s4_remy_reg  <= |y_full[27:0];
            s4_z_reg     <= s3_z_reg;
            s4_neg_x_reg <= s3_neg_x_reg;
            s4_neg_y_reg <= s3_neg_y_reg;
            s4_r_reg     <= s3_r_reg;
            s4_g_reg     <= s3_g_reg;
            s4_b_reg     <= s3_b_reg;

            out_word_reg <= out_word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

`ifndef SYNTHESIS
    // a stalled output freezes the whole pipe
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(s2_valid_reg) && $stable(s4_valid_reg)))
        else $error("pipeline moved during output stall");
`endif

endmodule

### tb/depth_pixel_backprojection_core_test.sv
`timescale 1ns / 1ps
// ============================================================================
// depth_pixel_backprojection_core_test: self-checking bench for the core
// Drives raster pixel words (well-formed frames, ragged lines and noise)
// under a series of register settings, predicts every point word in a
// scoreboard class and compares each accepted output word field by field.
// ============================================================================
module depth_pixel_backprojection_core_test;
    import dpb_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 16;       // > pipe latency + queue
    localparam int PIX_STRIDE    = 3;
    localparam int PIX_MAX_DIM   = 4096;
    localparam int MAX_GAP       = 17;
    localparam int REPORT_LIMIT  = 10;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors registers and raster counters, queues point words
    // ------------------------------------------------------------------------
    class point_tracker;
        cfg_t        regs;
        int unsigned col_idx;
        int unsigned row_idx;
        int unsigned col_ph;
        int unsigned row_ph;
        out_word_t   expected_points[$];
        int unsigned errors;
        int unsigned points_checked;
        int unsigned pixels_seen;

        function new();
            regs.depth_scale = 24'd16777;
            regs.min_depth   = 32'd655;
            regs.max_depth   = 32'd655360;
            regs.center_x    = 16'd5087;
            regs.center_y    = 16'd3865;
            regs.inv_focal_x = 24'd32559;
            regs.inv_focal_y = 24'd32410;
            regs.swap_color  = 1'b0;
            col_idx = 0;
            row_idx = 0;
            col_ph  = 0;
            row_ph  = 0;
            errors = 0;
            points_checked = 0;
            pixels_seen = 0;
        endfunction

        function void write_reg(reg_index_t idx, logic [31:0] data);
            case (idx)
                REG_DEPTH_SCALE: regs.depth_scale = data[23:0];
                REG_MIN_DEPTH:   regs.min_depth   = data;
                REG_MAX_DEPTH:   regs.max_depth   = data;
                REG_CENTER_X:    regs.center_x    = data[15:0];
                REG_CENTER_Y:    regs.center_y    = data[15:0];
                REG_INV_FOCAL_X: regs.inv_focal_x = data[23:0];
                REG_INV_FOCAL_Y: regs.inv_focal_y = data[23:0];
                REG_SWAP_COLOR:  regs.swap_color  = data[0];
                default: ;
            endcase
        endfunction

        // floor((16*idx - center) * z * inv / 2^28), saturated to 32 bits
        function logic [31:0] back_project(int unsigned idx, logic [15:0] center,
                                           logic [31:0] z, logic [23:0] inv);
            longint       offset;
            logic [63:0]  mag;
            logic [127:0] prod;
            logic [127:0] quot;
            offset = longint'(idx) * 16 - longint'(center);
            mag    = (offset < 0) ? 64'(-offset) : 64'(offset);
            prod   = {64'd0, mag} * {96'd0, z} * {104'd0, inv};
            quot   = prod >> 28;
            if (offset < 0)
            begin
                if (prod[27:0] != 0)
                    quot = quot + 1;
                if (quot >= 128'h8000_0000)
                    return 32'h8000_0000;
                return -quot[31:0];
            end
            if (quot > 128'h7FFF_FFFF)
                return 32'h7FFF_FFFF;
            return quot[31:0];
        endfunction

        function void note_pixel(in_word_t w);
            logic [39:0] scaled;
            logic [31:0] z;
            out_word_t   pt;
            pixels_seen++;
            if (w.start_of_frame)
            begin
                col_idx = 0;
                row_idx = 0;
                col_ph  = 0;
                row_ph  = 0;
            end
            if (col_ph == 0 && row_ph == 0)
            begin
                scaled = {24'd0, w.depth_raw} * {16'd0, regs.depth_scale};
                z      = scaled[39:8];
                if (z >= regs.min_depth && z <= regs.max_depth)
                begin
                    pt.point_x = back_project(col_idx, regs.center_x, z, regs.inv_focal_x);
                    pt.point_y = back_project(row_idx, regs.center_y, z, regs.inv_focal_y);
                    pt.point_z = z;
                    pt.red     = regs.swap_color ? w.third_byte : w.first_byte;
                    pt.green   = w.second_byte;
                    pt.blue    = regs.swap_color ? w.first_byte : w.third_byte;
                    expected_points = {expected_points, pt};
                end
            end
            // counters wrap at the raster limit, phases run on their own
            if (w.end_of_line)
            begin
                col_idx = 0;
                col_ph  = 0;
                row_idx = (row_idx + 1 >= PIX_MAX_DIM) ? 0 : row_idx + 1;
                row_ph  = (row_ph + 1 >= PIX_STRIDE) ? 0 : row_ph + 1;
            end
            else
            begin
                col_idx = (col_idx + 1 >= PIX_MAX_DIM) ? 0 : col_idx + 1;
                col_ph  = (col_ph + 1 >= PIX_STRIDE) ? 0 : col_ph + 1;
            end
        endfunction

        function void check_point(out_word_t got);
            out_word_t want;
            if (expected_points.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected point word: x=%0d y=%0d z=%0d rgb=%02h %02h %02h",
                             got.point_x, got.point_y, got.point_z,
                             got.red, got.green, got.blue);
                return;
            end
            want = expected_points.pop_front();
            points_checked++;
            if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
                got.point_z !== want.point_z || got.red !== want.red ||
                got.green !== want.green || got.blue !== want.blue)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                begin
                    $display("point %0d mismatch", points_checked);
                    $display("  want x=%0d y=%0d z=%0d rgb=%02h %02h %02h",
                             want.point_x, want.point_y, want.point_z,
                             want.red, want.green, want.blue);
                    $display("  got  x=%0d y=%0d z=%0d rgb=%02h %02h %02h",
                             got.point_x, got.point_y, got.point_z,
                             got.red, got.green, got.blue);
                end
            end
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_word_t    in_word;
    logic        out_valid;
    logic        out_ready;
    out_word_t   out_word;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    depth_pixel_backprojection_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    point_tracker tracker = new();

    bit send_quiet   = 1'b0;   // sender: no gaps between words
    bit sink_quiet   = 1'b0;   // receiver: no stalls between words
    int hold_request = 0;      // long receiver stall, picked up by the sink
    int hold_left    = 0;
    int sink_wait    = 0;
    int cycle_count  = 0;
    int config_loads = 0;

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d point words outstanding",
                     cycle_count, tracker.pending());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: ready driven at the falling edge
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (sink_wait > 0)
            begin
                sink_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Output word accepted at this edge: check it and draw the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            tracker.check_point(out_word);
            sink_wait = sink_quiet ? 0 : $urandom_range(0, MAX_GAP);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic send_pixel(input in_word_t w);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_pixel(w);
    endtask

    // Sender idles until every point word is back and the pipe has drained
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input reg_index_t idx, input logic [31:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        tracker.write_reg(idx, data);
    endtask

    task automatic load_config(input cfg_t c);
        settle();
        put_reg(REG_DEPTH_SCALE, 32'(c.depth_scale));
        put_reg(REG_MIN_DEPTH,   c.min_depth);
        put_reg(REG_MAX_DEPTH,   c.max_depth);
        put_reg(REG_CENTER_X,    32'(c.center_x));
        put_reg(REG_CENTER_Y,    32'(c.center_y));
        put_reg(REG_INV_FOCAL_X, 32'(c.inv_focal_x));
        put_reg(REG_INV_FOCAL_Y, 32'(c.inv_focal_y));
        put_reg(REG_SWAP_COLOR,  32'(c.swap_color));
        config_loads++;
    endtask

    function automatic in_word_t make_pixel(logic [15:0] raw, logic [7:0] b0,
                                            logic [7:0] b1, logic [7:0] b2,
                                            logic sof, logic eol);
        in_word_t w;
        w.depth_raw      = raw;
        w.first_byte     = b0;
        w.second_byte    = b1;
        w.third_byte     = b2;
        w.start_of_frame = sof;
        w.end_of_line    = eol;
        return w;
    endfunction

    function automatic in_word_t random_pixel();
        in_word_t w;
        int       pick;
        pick = $urandom_range(0, 15);
        w.depth_raw      = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
        w.first_byte     = 8'($urandom);
        w.second_byte    = 8'($urandom);
        w.third_byte     = 8'($urandom);
        w.start_of_frame = 1'b0;
        w.end_of_line    = 1'b0;
        return w;
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t c;
        c.depth_scale = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(1, 24'hFFFFFF))
                                                    : 24'($urandom_range(1, 24'h00FFFF));
        c.min_depth   = $urandom_range(0, 32'h0001_0000);
        c.max_depth   = ($urandom_range(0, 3) == 0) ? $urandom : 32'hFFFF_FFFF;
        c.center_x    = 16'($urandom);
        c.center_y    = 16'($urandom);
        c.inv_focal_x = ($urandom_range(0, 1) == 0) ? 24'($urandom_range(1, 24'h00FFFF))
                                                    : 24'($urandom_range(1, 24'hFFFFFF));
        c.inv_focal_y = ($urandom_range(0, 1) == 0) ? 24'($urandom_range(1, 24'h00FFFF))
                                                    : 24'($urandom_range(1, 24'hFFFFFF));
        c.swap_color  = 1'($urandom);
        return c;
    endfunction

    // Raster frame; a ragged one places end-of-line flags at random
    task automatic send_frame(input int width, input int height, input bit ragged);
        in_word_t w;
        for (int r = 0; r < height; r++)
        begin
            for (int c = 0; c < width; c++)
            begin
                w = random_pixel();
                w.start_of_frame = (r == 0 && c == 0);
                w.end_of_line    = ragged ? ($urandom_range(0, 7) == 0) : (c == width - 1);
                send_pixel(w);
            end
        end
    endtask

    task automatic send_noise(input int count);
        in_word_t w;
        repeat (count)
        begin
            w = random_pixel();
            w.start_of_frame = 1'($urandom);
            w.end_of_line    = 1'($urandom);
            send_pixel(w);
        end
    endtask

    // Mostly well-formed frames, some ragged lines and loose noise words
    task automatic run_traffic(input int target);
        int start;
        int kind;
        start = tracker.pixels_seen;
        while (tracker.pixels_seen - start < target)
        begin
            send_quiet = ($urandom_range(0, 5) == 0);
            sink_quiet = ($urandom_range(0, 5) == 0);
            kind = $urandom_range(0, 9);
            if (kind == 0)
                send_noise($urandom_range(1, 6));
            else if (kind == 1)
                send_frame($urandom_range(2, 16), $urandom_range(1, 6), 1'b1);
            else
                send_frame($urandom_range(1, 24), $urandom_range(1, 9), 1'b0);
        end
        send_quiet = 1'b0;
        sink_quiet = 1'b0;
    endtask

    initial
    begin
        cfg_t c;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_write = 1'b0;
        cfg_index = REG_DEPTH_SCALE;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: window edges (raw 10 lands exactly on min_depth),
        // field extremes, start of frame on its own and mid-row
        send_pixel(make_pixel(16'd10,    8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
        send_pixel(make_pixel(16'd9,     8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0));
        send_pixel(make_pixel(16'd10000, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0));
        send_pixel(make_pixel(16'd10001, 8'h5A, 8'hA5, 8'h3C, 1'b1, 1'b0));
        send_pixel(make_pixel(16'd0,     8'h12, 8'h34, 8'h56, 1'b1, 1'b0));
        send_pixel(make_pixel(16'hFFFF,  8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0));
        send_pixel(make_pixel(16'd3000,  8'h01, 8'h02, 8'h03, 1'b1, 1'b1));
        send_frame(4, 4, 1'b0);
        send_pixel(make_pixel(16'd2000,  8'h11, 8'h22, 8'h33, 1'b0, 1'b0));
        send_pixel(make_pixel(16'd2000,  8'h44, 8'h55, 8'h66, 1'b0, 1'b0));
        send_pixel(make_pixel(16'd2000,  8'h77, 8'h88, 8'h99, 1'b1, 1'b0));

        // Unit depth scale gives z = raw: inclusive window on both ends,
        // swapped color order, principal point at both extremes
        c = '{depth_scale: 24'd256, min_depth: 32'd100, max_depth: 32'd200,
              center_x: 16'd0, center_y: 16'hFFFF, inv_focal_x: 24'h010000,
              inv_focal_y: 24'h010000, swap_color: 1'b1};
        load_config(c);
        send_pixel(make_pixel(16'd99,  8'hAA, 8'hBB, 8'hCC, 1'b1, 1'b0));
        send_pixel(make_pixel(16'd100, 8'hAA, 8'hBB, 8'hCC, 1'b1, 1'b0));
        send_pixel(make_pixel(16'd200, 8'hAA, 8'hBB, 8'hCC, 1'b1, 1'b0));
        send_pixel(make_pixel(16'd201, 8'hAA, 8'hBB, 8'hCC, 1'b1, 1'b0));

        // Largest settings: coordinates saturate; receiver holds off while
        // the sender streams, then the sender waits for the backlog
        c = '{depth_scale: 24'hFFFFFF, min_depth: 32'd0, max_depth: 32'hFFFF_FFFF,
              center_x: 16'd0, center_y: 16'hFFFF, inv_focal_x: 24'hFFFFFF,
              inv_focal_y: 24'hFFFFFF, swap_color: 1'b1};
        load_config(c);
        settle();
        hold_request = 400;
        send_quiet   = 1'b1;
        send_frame(24, 8, 1'b0);
        send_quiet   = 1'b0;
        settle();
        run_traffic(100);

        // Smallest nonzero reciprocals
        c = '{depth_scale: 24'd1, min_depth: 32'd0, max_depth: 32'hFFFF_FFFF,
              center_x: 16'hFFFF, center_y: 16'd0, inv_focal_x: 24'd1,
              inv_focal_y: 24'd1, swap_color: 1'b0};
        load_config(c);
        run_traffic(100);

        // Zero reciprocals: z and both coordinates come out as zero
        c = '{depth_scale: 24'd0, min_depth: 32'd0, max_depth: 32'd0,
              center_x: 16'd5087, center_y: 16'd3865, inv_focal_x: 24'd0,
              inv_focal_y: 24'd0, swap_color: 1'b1};
        load_config(c);
        run_traffic(70);

        // Inverted window drops everything
        c = '{depth_scale: 24'd16777, min_depth: 32'd655361, max_depth: 32'd655,
              center_x: 16'd5087, center_y: 16'd3865, inv_focal_x: 24'd32559,
              inv_focal_y: 24'd32410, swap_color: 1'b0};
        load_config(c);
        run_traffic(70);

        // Camera-like settings with the full depth window
        c = '{depth_scale: 24'd16777, min_depth: 32'd0, max_depth: 32'hFFFF_FFFF,
              center_x: 16'd5087, center_y: 16'd3865, inv_focal_x: 24'd32559,
              inv_focal_y: 24'd32410, swap_color: 1'b0};
        load_config(c);
        run_traffic(100);

        repeat (4)
        begin
            load_config(random_cfg());
            run_traffic(80);
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d pixel words under %0d register settings, checked %0d point words",
                 tracker.pixels_seen, config_loads, tracker.points_checked);
        $display("Included window edges, saturation, zero reciprocals, inverted window, long stall");
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d errors, %0d point words never arrived",
                     tracker.errors, tracker.pending());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/dpb_pkg.sv
rtl/dpb_front.sv
rtl/dpb_queue.sv
rtl/dpb_back.sv
rtl/depth_pixel_backprojection_core.sv
tb/depth_pixel_backprojection_core_test.sv
